[rtl/swarq_pkg.sv]
package swarq_pkg;

   // request opcodes
   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_CAD     = 3'd1;
   localparam logic [2:0] OP_TX_DONE = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_RX      = 3'd4;

   // response actions
   localparam logic [1:0] ACT_TX  = 2'd0;
   localparam logic [1:0] ACT_RX  = 2'd1;
   localparam logic [1:0] ACT_FWD = 2'd2;
   localparam logic [1:0] ACT_FIN = 2'd3;

   // finish outcomes
   localparam logic [1:0] OUT_OK       = 2'd0;
   localparam logic [1:0] OUT_NACK     = 2'd1;
   localparam logic [1:0] OUT_TIMEOUT  = 2'd2;
   localparam logic [1:0] OUT_CAD_FAIL = 2'd3;

   // csr indexes
   localparam logic [2:0] CSR_MAX_RETX    = 3'd0;
   localparam logic [2:0] CSR_TXD_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_ACK_CODE    = 3'd2;
   localparam logic [2:0] CSR_NACK_CODE   = 3'd3;
   localparam logic [2:0] CSR_FWD_ENABLE  = 3'd4;

   // csr reset values
   localparam logic [3:0]  MAX_RETX_RST    = 4'd3;
   localparam logic [15:0] TXD_TIMEOUT_RST = 16'd5000;
   localparam logic [7:0]  ACK_CODE_RST    = 8'd1;
   localparam logic [7:0]  NACK_CODE_RST   = 8'd2;

   localparam logic [7:0] MIN_ACK_LEN = 8'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] tx_length;
      logic       retx_flag;
      logic [3:0] attempt_number;
      logic [1:0] outcome;
      logic       last_result;
   } rsp_type;

endpackage

[rtl/stop_and_wait_arq_sender_core.sv]
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | opcode, sequence, lengths, rx frame fields
// rsp     | out       | rsp_valid/rsp_stall | action, tx length, retx, attempt, outcome, last
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One request is taken per cycle while req_stall is low; its responses (zero, one or
// two) land in a four-entry response queue in the same edge and appear one per cycle
// while rsp_stall is low. req_stall rises while fewer than two queue slots are free,
// so the queue drain rate on rsp sets the throughput when requests make two responses.
// Synchronous active-high reset returns the csr values and the exchange to idle.
module stop_and_wait_arq_sender_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_sequence_number,
   input  logic [7:0] req_frame_length,
   input  logic [15:0] req_timeout_ticks,
   input  logic       req_cad_gave_up,
   input  logic       req_rx_valid,
   input  logic [7:0] req_rx_type,
   input  logic [7:0] req_rx_length,
   input  logic [7:0] req_rx_ack_sequence,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_action,
   output logic [7:0] rsp_tx_length,
   output logic       rsp_retx_flag,
   output logic [3:0] rsp_attempt_number,
   output logic [1:0] rsp_outcome,
   output logic       rsp_last_result,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int QDEPTH = 4;

   typedef enum logic [1:0] {PH_IDLE, PH_CAD, PH_TXD, PH_ACK} phase_type;

   phase_type                phase_ff, phase_in;
   logic [3:0]               attempt_ff, attempt_in;
   logic [TIMER_BITS-1:0]    countdown_ff, countdown_in;
   logic [7:0]               exp_seq_ff, exp_seq_in;
   logic [7:0]               saved_len_ff, saved_len_in;
   logic [TIMER_BITS-1:0]    reload_ff, reload_in;

   logic [3:0]               max_retx_ff;
   logic [15:0]              txd_timeout_ff;
   logic [7:0]               ack_code_ff;
   logic [7:0]               nack_code_ff;
   logic                     fwd_en_ff;

   swarq_pkg::rsp_type       queue_ff [QDEPTH];
   swarq_pkg::rsp_type       queue_in [QDEPTH];
   logic [2:0]               count_ff, count_in;

   swarq_pkg::rsp_type       r0, r1;
   logic [1:0]               n_rsp;
   logic                     req_accept, rsp_accept, csr_write;
   logic                     expired, match;
   logic [2:0]               base;

   function automatic swarq_pkg::rsp_type mk(input logic [1:0] action,
                                              input logic [7:0] len,
                                              input logic       retx,
                                              input logic [3:0] attempt,
                                              input logic [1:0] outcome);
      swarq_pkg::rsp_type r;
      r.action         = action;
      r.tx_length      = len;
      r.retx_flag      = retx;
      r.attempt_number = attempt;
      r.outcome        = outcome;
      r.last_result    = 1'b0;
      return r;
   endfunction

   assign req_stall  = (count_ff > 3'(QDEPTH - 2));
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = (count_ff != 3'd0);
   assign rsp_accept = rsp_valid & ~rsp_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;

   assign rsp_action         = queue_ff[0].action;
   assign rsp_tx_length      = queue_ff[0].tx_length;
   assign rsp_retx_flag      = queue_ff[0].retx_flag;
   assign rsp_attempt_number = queue_ff[0].attempt_number;
   assign rsp_outcome        = queue_ff[0].outcome;
   assign rsp_last_result    = queue_ff[0].last_result;

   assign expired = (countdown_ff <= TIMER_BITS'(1));
   assign match   = (req_rx_length >= swarq_pkg::MIN_ACK_LEN) &&
                    (req_rx_ack_sequence == exp_seq_ff);

   // request decode: next exchange state and up to two responses
   always_comb begin
      phase_in     = phase_ff;
      attempt_in   = attempt_ff;
      countdown_in = countdown_ff;
      exp_seq_in   = exp_seq_ff;
      saved_len_in = saved_len_ff;
      reload_in    = reload_ff;
      n_rsp        = 2'd0;
      r0           = '0;
      r1           = '0;
      if (req_accept) begin
         case (req_opcode)
            swarq_pkg::OP_START: begin
               exp_seq_in   = req_sequence_number;
               saved_len_in = req_frame_length;
               reload_in    = TIMER_BITS'(req_timeout_ticks);
               attempt_in   = 4'd0;
               countdown_in = '0;
               phase_in     = PH_CAD;
            end
            swarq_pkg::OP_CAD: begin
               if (phase_ff == PH_CAD) begin
                  n_rsp = 2'd1;
                  if (req_cad_gave_up) begin
                     r0 = mk(swarq_pkg::ACT_FIN, 8'd0, 1'b0, attempt_ff,
                             swarq_pkg::OUT_CAD_FAIL);
                     phase_in = PH_IDLE;
                  end else begin
                     r0 = mk(swarq_pkg::ACT_TX, saved_len_ff, 1'b0, attempt_ff,
                             swarq_pkg::OUT_OK);
                     countdown_in = TIMER_BITS'(txd_timeout_ff);
                     phase_in     = PH_TXD;
                  end
               end
            end
            swarq_pkg::OP_TX_DONE: begin
               if (phase_ff == PH_TXD) begin
                  n_rsp        = 2'd1;
                  r0           = mk(swarq_pkg::ACT_RX, 8'd0, 1'b0, attempt_ff,
                                    swarq_pkg::OUT_OK);
                  countdown_in = reload_ff;
                  phase_in     = PH_ACK;
               end
            end
            swarq_pkg::OP_TICK: begin
               if (phase_ff == PH_TXD) begin
                  if (expired) begin
                     n_rsp        = 2'd1;
                     r0           = mk(swarq_pkg::ACT_RX, 8'd0, 1'b0, attempt_ff,
                                       swarq_pkg::OUT_OK);
                     countdown_in = reload_ff;
                     phase_in     = PH_ACK;
                  end else begin
                     countdown_in = countdown_ff - TIMER_BITS'(1);
                  end
               end else if (phase_ff == PH_ACK) begin
                  if (expired) begin
                     n_rsp = 2'd1;
                     if (attempt_ff < max_retx_ff) begin
                        // retransmit with the bumped attempt index
                        attempt_in   = attempt_ff + 4'd1;
                        r0           = mk(swarq_pkg::ACT_TX, saved_len_ff, 1'b1,
                                          attempt_ff + 4'd1, swarq_pkg::OUT_OK);
                        countdown_in = TIMER_BITS'(txd_timeout_ff);
                        phase_in     = PH_TXD;
                     end else begin
                        r0           = mk(swarq_pkg::ACT_FIN, 8'd0, 1'b0, attempt_ff,
                                          swarq_pkg::OUT_TIMEOUT);
                        countdown_in = '0;
                        phase_in     = PH_IDLE;
                     end
                  end else begin
                     countdown_in = countdown_ff - TIMER_BITS'(1);
                  end
               end
            end
            swarq_pkg::OP_RX: begin
               if (phase_ff == PH_ACK) begin
                  n_rsp = 2'd1;
                  if (!req_rx_valid) begin
                     r0 = mk(swarq_pkg::ACT_RX, 8'd0, 1'b0, attempt_ff,
                             swarq_pkg::OUT_OK);
                  end else if (match && req_rx_type == ack_code_ff) begin
                     r0       = mk(swarq_pkg::ACT_FIN, 8'd0, 1'b0, attempt_ff,
                                   swarq_pkg::OUT_OK);
                     phase_in = PH_IDLE;
                  end else if (match && req_rx_type == nack_code_ff) begin
                     r0       = mk(swarq_pkg::ACT_FIN, 8'd0, 1'b0, attempt_ff,
                                   swarq_pkg::OUT_NACK);
                     phase_in = PH_IDLE;
                  end else if (fwd_en_ff) begin
                     n_rsp = 2'd2;
                     r0    = mk(swarq_pkg::ACT_FWD, 8'd0, 1'b0, attempt_ff,
                                swarq_pkg::OUT_OK);
                     r1    = mk(swarq_pkg::ACT_RX, 8'd0, 1'b0, attempt_ff,
                                swarq_pkg::OUT_OK);
                  end else begin
                     r0 = mk(swarq_pkg::ACT_RX, 8'd0, 1'b0, attempt_ff,
                             swarq_pkg::OUT_OK);
                  end
               end
            end
            default: begin
            end
         endcase
      end
      r0.last_result = (n_rsp == 2'd1);
      r1.last_result = 1'b1;
   end

   // response queue: shift out at the head, append behind the survivors
   always_comb begin
      base = count_ff - {2'b00, rsp_accept};
      for (int i = 0; i < QDEPTH; i++) begin
         if (rsp_accept && i < QDEPTH - 1) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (n_rsp != 2'd0 && base == 3'(i)) begin
            queue_in[i] = r0;
         end
         if (n_rsp == 2'd2 && base + 3'd1 == 3'(i)) begin
            queue_in[i] = r1;
         end
      end
      count_in = base + {1'b0, n_rsp};
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
      if (reset) begin
         phase_ff       <= PH_IDLE;
         attempt_ff     <= 4'd0;
         countdown_ff   <= '0;
         exp_seq_ff     <= 8'd0;
         saved_len_ff   <= 8'd0;
         reload_ff      <= '0;
         count_ff       <= 3'd0;
         max_retx_ff    <= swarq_pkg::MAX_RETX_RST;
         txd_timeout_ff <= swarq_pkg::TXD_TIMEOUT_RST;
         ack_code_ff    <= swarq_pkg::ACK_CODE_RST;
         nack_code_ff   <= swarq_pkg::NACK_CODE_RST;
         fwd_en_ff      <= 1'b1;
      end else begin
         phase_ff     <= phase_in;
         attempt_ff   <= attempt_in;
         countdown_ff <= countdown_in;
         exp_seq_ff   <= exp_seq_in;
         saved_len_ff <= saved_len_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         if (csr_write) begin
            case (csr_index)
               swarq_pkg::CSR_MAX_RETX:    max_retx_ff    <= csr_wdata[3:0];
               swarq_pkg::CSR_TXD_TIMEOUT: txd_timeout_ff <= csr_wdata;
               swarq_pkg::CSR_ACK_CODE:    ack_code_ff    <= csr_wdata[7:0];
               swarq_pkg::CSR_NACK_CODE:   nack_code_ff   <= csr_wdata[7:0];
               swarq_pkg::CSR_FWD_ENABLE:  fwd_en_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule
